// ===== design/bba_pkg.sv =====
package bba_pkg;

  localparam int LEVELS_DEF = 10;

  typedef enum logic [1:0] {
    NODE_UNUSED = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_ALLOC  = 2'd2,
    NODE_SPLIT  = 2'd3
  } node_st_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef struct packed {
    logic        func;
    logic [10:0] req_units;
    logic [9:0]  free_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  block_addr;
    logic [10:0] block_units;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_INIT,
    S_A_RD,
    S_A_CHK,
    S_A_SPL,
    S_A_SPR,
    S_A_MARK,
    S_F_RD,
    S_F_CHK,
    S_M_RD,
    S_M_CHK,
    S_M_BUD,
    S_M_UP,
    S_DONE
  } state_t;

endpackage

// ===== design/bba_mem.sv =====
module bba_mem #(
  parameter int DEPTH = 2047,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rdata
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/buddy_block_allocator.sv =====
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid, req_stall  | bba_pkg::req_t (func, req_units, free_addr)
// rsp     | out       | rsp_valid, rsp_stall  | bba_pkg::rsp_t (status, block_addr, block_units)
//
// One transaction is worked at a time; the tree state lives in a single memory with one
// read and one write port. An allocation scans tree levels from the target level upward
// (S_A_RD, S_A_CHK per node examined), then splits each level (S_A_SPL, S_A_SPR). A free
// walks down (S_F_RD, S_F_CHK per level) and merges (S_M_RD, S_M_CHK, S_M_BUD, S_M_UP per
// level). After reset a clearing pass over all (2 << LEVELS) - 1 nodes holds req_stall
// high. A finished result waits in the output register while rsp_stall is high; the next
// request is taken in the meantime and held at its end if still stalled.
module buddy_block_allocator #(
  parameter int LEVELS = bba_pkg::LEVELS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bba_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bba_pkg::rsp_t  rsp
);

  // Node index width, depth counter width, address width and a wide compare width.
  localparam int NODE_COUNT = (2 << LEVELS) - 1;
  localparam int NW = LEVELS + 1;
  localparam int DW = $clog2(LEVELS + 1);
  localparam int LW = LEVELS;
  localparam int WW = LEVELS + 12;
  localparam logic [WW-1:0] POOL = WW'(1) << LEVELS;

  bba_pkg::state_t state, state_next;

  logic [NW-1:0] node, node_next;
  logic [DW-1:0] dep, dep_next;
  logic [DW-1:0] tgt, tgt_next;
  logic [LW-1:0] k, k_next;
  logic [LW-1:0] start, start_next;
  logic [10:0]   r_units, r_units_next;
  logic [9:0]    f_addr, f_addr_next;
  logic [1:0]    res_status, res_status_next;
  logic [9:0]    res_addr, res_addr_next;
  logic [10:0]   res_units, res_units_next;
  logic          load_rsp;

  logic          we;
  logic [NW-1:0] waddr;
  logic [NW-1:0] raddr;
  bba_pkg::node_st_t wdata;
  logic [1:0]    rdata_raw;
  bba_pkg::node_st_t rdata;

  assign rdata = bba_pkg::node_st_t'(rdata_raw);

  bba_mem #(
    .DEPTH (NODE_COUNT),
    .AW    (NW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  // Size in units of a block at the given depth.
  function automatic logic [LEVELS:0] blk_size(input logic [DW-1:0] d);
    blk_size = (LEVELS + 1)'(1) << (LEVELS - int'(d));
  endfunction

  // Index of the leftmost node at the given depth.
  function automatic logic [NW-1:0] level_first(input logic [DW-1:0] d);
    level_first = NW'((WW'(1) << d) - WW'(1));
  endfunction

  logic [10:0]   r_eff;
  logic [DW-1:0] tlog;
  logic [WW-1:0] half;
  logic [NW-1:0] buddy;
  logic [NW-1:0] parent;
  logic [DW-1:0] dep_dn;

  always_comb begin
    r_eff = (r_units == 11'd0) ? 11'd1 : r_units;
    tlog = DW'(LEVELS);
    // Smallest block exponent whose size covers the request.
    for (int t = LEVELS; t >= 0; t--) begin
      if ((WW'(1) << t) >= WW'(r_eff)) begin
        tlog = DW'(t);
      end
    end
    half = (LEVELS - int'(dep) - 1 >= 0) ? (WW'(1) << (LEVELS - int'(dep) - 1)) : WW'(0);
    buddy = node[0] ? (node + NW'(1)) : (node - NW'(1));
    parent = (node - NW'(1)) >> 1;
    dep_dn = dep - DW'(1);
  end

  always_comb begin
    state_next      = state;
    node_next       = node;
    dep_next        = dep;
    tgt_next        = tgt;
    k_next          = k;
    start_next      = start;
    r_units_next    = r_units;
    f_addr_next     = f_addr;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    res_units_next  = res_units;
    load_rsp        = 1'b0;
    we              = 1'b0;
    waddr           = node;
    wdata           = bba_pkg::NODE_UNUSED;
    raddr           = node;
    req_stall       = (state != bba_pkg::S_IDLE);

    unique case (state)
      bba_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = node;
        wdata = (node == '0) ? bba_pkg::NODE_FREE : bba_pkg::NODE_UNUSED;
        if (node == NW'(NODE_COUNT - 1)) begin
          state_next = bba_pkg::S_IDLE;
        end else begin
          node_next = node + NW'(1);
        end
      end
      bba_pkg::S_IDLE: begin
        if (req_valid) begin
          r_units_next = req.req_units;
          f_addr_next  = req.free_addr;
          node_next    = '0;
          dep_next     = '0;
          start_next   = '0;
          k_next       = '0;
          if (req.func == bba_pkg::FUNC_FREE) begin
            if (WW'(req.free_addr) >= POOL) begin
              res_status_next = bba_pkg::ST_BAD_FREE;
              res_addr_next   = '0;
              res_units_next  = '0;
              state_next      = bba_pkg::S_DONE;
            end else begin
              state_next = bba_pkg::S_F_RD;
            end
          end else begin
            state_next = bba_pkg::S_A_INIT;
          end
        end
      end
      bba_pkg::S_A_INIT: begin
        if (WW'(r_eff) > POOL) begin
          res_status_next = bba_pkg::ST_TOO_LARGE;
          res_addr_next   = '0;
          res_units_next  = '0;
          state_next      = bba_pkg::S_DONE;
        end else begin
          tgt_next   = DW'(LEVELS) - tlog;
          dep_next   = DW'(LEVELS) - tlog;
          k_next     = '0;
          state_next = bba_pkg::S_A_RD;
        end
      end
      bba_pkg::S_A_RD: begin
        raddr      = level_first(dep) + NW'(k);
        node_next  = level_first(dep) + NW'(k);
        state_next = bba_pkg::S_A_CHK;
      end
      bba_pkg::S_A_CHK: begin
        if (rdata == bba_pkg::NODE_FREE) begin
          state_next = (dep < tgt) ? bba_pkg::S_A_SPL : bba_pkg::S_A_MARK;
        end else if (WW'(k) == (WW'(1) << dep) - WW'(1)) begin
          if (dep == '0) begin
            res_status_next = bba_pkg::ST_NO_SPACE;
            res_addr_next   = '0;
            res_units_next  = '0;
            state_next      = bba_pkg::S_DONE;
          end else begin
            dep_next   = dep_dn;
            k_next     = '0;
            state_next = bba_pkg::S_A_RD;
          end
        end else begin
          k_next     = k + LW'(1);
          state_next = bba_pkg::S_A_RD;
        end
      end
      bba_pkg::S_A_SPL: begin
        we         = 1'b1;
        waddr      = node;
        wdata      = bba_pkg::NODE_SPLIT;
        state_next = bba_pkg::S_A_SPR;
      end
      bba_pkg::S_A_SPR: begin
        // The right half becomes free and the walk continues into the left half.
        we         = 1'b1;
        waddr      = NW'({node, 1'b0}) + NW'(2);
        wdata      = bba_pkg::NODE_FREE;
        node_next  = NW'({node, 1'b0}) + NW'(1);
        k_next     = LW'({k, 1'b0});
        dep_next   = dep + DW'(1);
        state_next = ((dep + DW'(1)) < tgt) ? bba_pkg::S_A_SPL : bba_pkg::S_A_MARK;
      end
      bba_pkg::S_A_MARK: begin
        we              = 1'b1;
        waddr           = node;
        wdata           = bba_pkg::NODE_ALLOC;
        res_status_next = bba_pkg::ST_OK;
        res_addr_next   = 10'(k << (LEVELS - int'(dep)));
        res_units_next  = 11'(blk_size(dep));
        state_next      = bba_pkg::S_DONE;
      end
      bba_pkg::S_F_RD: begin
        raddr      = node;
        state_next = bba_pkg::S_F_CHK;
      end
      bba_pkg::S_F_CHK: begin
        if (rdata == bba_pkg::NODE_SPLIT && int'(dep) < LEVELS) begin
          if (WW'(f_addr) >= WW'(start) + half) begin
            start_next = LW'(WW'(start) + half);
            node_next  = NW'({node, 1'b0}) + NW'(2);
          end else begin
            node_next  = NW'({node, 1'b0}) + NW'(1);
          end
          dep_next   = dep + DW'(1);
          state_next = bba_pkg::S_F_RD;
        end else if (rdata != bba_pkg::NODE_ALLOC || WW'(start) != WW'(f_addr)) begin
          res_status_next = bba_pkg::ST_BAD_FREE;
          res_addr_next   = '0;
          res_units_next  = '0;
          state_next      = bba_pkg::S_DONE;
        end else begin
          we         = 1'b1;
          waddr      = node;
          wdata      = bba_pkg::NODE_FREE;
          state_next = bba_pkg::S_M_RD;
        end
      end
      bba_pkg::S_M_RD: begin
        if (node == '0) begin
          res_status_next = bba_pkg::ST_OK;
          res_addr_next   = 10'(start);
          res_units_next  = 11'(blk_size(dep));
          state_next      = bba_pkg::S_DONE;
        end else begin
          raddr      = buddy;
          state_next = bba_pkg::S_M_CHK;
        end
      end
      bba_pkg::S_M_CHK: begin
        if (rdata != bba_pkg::NODE_FREE) begin
          res_status_next = bba_pkg::ST_OK;
          res_addr_next   = 10'(start);
          res_units_next  = 11'(blk_size(dep));
          state_next      = bba_pkg::S_DONE;
        end else begin
          we         = 1'b1;
          waddr      = node;
          wdata      = bba_pkg::NODE_UNUSED;
          state_next = bba_pkg::S_M_BUD;
        end
      end
      bba_pkg::S_M_BUD: begin
        we         = 1'b1;
        waddr      = buddy;
        wdata      = bba_pkg::NODE_UNUSED;
        state_next = bba_pkg::S_M_UP;
      end
      bba_pkg::S_M_UP: begin
        we         = 1'b1;
        waddr      = parent;
        wdata      = bba_pkg::NODE_FREE;
        node_next  = parent;
        dep_next   = dep_dn;
        start_next = start & ~LW'((WW'(1) << (LEVELS - int'(dep_dn))) - WW'(1));
        state_next = bba_pkg::S_M_RD;
      end
      bba_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::S_CLEAR;
      node      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      node  <= node_next;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dep        <= dep_next;
    tgt        <= tgt_next;
    k          <= k_next;
    start      <= start_next;
    r_units    <= r_units_next;
    f_addr     <= f_addr_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    res_units  <= res_units_next;
    if (load_rsp) begin
      rsp.status      <= res_status;
      rsp.block_addr  <= res_addr;
      rsp.block_units <= res_units;
    end
  end

`ifndef SYNTHESIS
  // A result leaving the done state must show up on the output.
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_DONE && !rsp_valid) |=> rsp_valid)
    else $error("result not presented after done state");

  // Error results carry no block.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != bba_pkg::ST_OK) |-> (rsp.block_units == 11'd0))
    else $error("error result with nonzero size");

  // Memory writes stay inside the tree.
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (int'(waddr) < NODE_COUNT))
    else $error("node write out of range");
`endif

endmodule

// ===== bench/bba_checker.sv =====
module bba_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  bba_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  bba_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending,
  output int            alloc_ok,
  output int            free_ok,
  output int            refused
);

  localparam int LV    = bba_pkg::LEVELS_DEF;
  localparam int NODES = (2 << LV) - 1;

  // Shadow copy of the block tree, one code per node.
  bba_pkg::node_st_t tree [0:NODES-1];
  bba_pkg::rsp_t     outcome_q [$];

  function automatic bba_pkg::rsp_t make_rsp(bba_pkg::status_t st, int unsigned addr,
                                             int unsigned units);
    bba_pkg::rsp_t r;
    r.status      = st;
    r.block_addr  = addr[9:0];
    r.block_units = units[10:0];
    return r;
  endfunction

  function automatic bba_pkg::rsp_t carve_block(int unsigned want);
    int unsigned tgt;
    int unsigned d;
    int unsigned first;
    int unsigned node;
    int unsigned offset;
    bit          found;
    node   = 0;
    offset = 0;
    found  = 0;
    if (want == 0) want = 1;
    if (want > (1 << LV)) return make_rsp(bba_pkg::ST_TOO_LARGE, 0, 0);
    tgt = LV;
    while ((1 << (LV - tgt)) < want) tgt--;
    // Best fit: scan from the target level toward the root, lowest address first.
    d = tgt + 1;
    while (d > 0 && !found) begin
      d--;
      first = (1 << d) - 1;
      for (int unsigned k = 0; k < (1 << d) && !found; k++) begin
        if (tree[first + k] == bba_pkg::NODE_FREE) begin
          node   = first + k;
          offset = k;
          found  = 1;
        end
      end
    end
    if (!found) return make_rsp(bba_pkg::ST_NO_SPACE, 0, 0);
    while (d < tgt) begin
      tree[node]         = bba_pkg::NODE_SPLIT;
      tree[2 * node + 2] = bba_pkg::NODE_FREE;
      node               = 2 * node + 1;
      offset             = 2 * offset;
      d++;
    end
    tree[node] = bba_pkg::NODE_ALLOC;
    return make_rsp(bba_pkg::ST_OK, offset << (LV - d), 1 << (LV - d));
  endfunction

  function automatic bba_pkg::rsp_t release_block(int unsigned addr);
    int unsigned node;
    int unsigned d;
    int unsigned start;
    int unsigned half;
    int unsigned buddy;
    node  = 0;
    d     = 0;
    start = 0;
    if (addr >= (1 << LV)) return make_rsp(bba_pkg::ST_BAD_FREE, 0, 0);
    while (tree[node] == bba_pkg::NODE_SPLIT && d < LV) begin
      half = 1 << (LV - d - 1);
      if (addr >= start + half) begin
        start += half;
        node = 2 * node + 2;
      end else begin
        node = 2 * node + 1;
      end
      d++;
    end
    if (tree[node] != bba_pkg::NODE_ALLOC || start != addr) begin
      return make_rsp(bba_pkg::ST_BAD_FREE, 0, 0);
    end
    tree[node] = bba_pkg::NODE_FREE;
    // Merge upward while the buddy is wholly free.
    while (node != 0) begin
      buddy = node[0] ? node + 1 : node - 1;
      if (tree[buddy] != bba_pkg::NODE_FREE) break;
      tree[node]  = bba_pkg::NODE_UNUSED;
      tree[buddy] = bba_pkg::NODE_UNUSED;
      node        = (node - 1) / 2;
      tree[node]  = bba_pkg::NODE_FREE;
      d--;
      start &= ~((1 << (LV - d)) - 1);
    end
    return make_rsp(bba_pkg::ST_OK, start, 1 << (LV - d));
  endfunction

  always @(posedge clk) begin
    bba_pkg::rsp_t want;
    if (rst) begin
      foreach (tree[i]) tree[i] = bba_pkg::NODE_UNUSED;
      tree[0] = bba_pkg::NODE_FREE;
      outcome_q.delete();
      fail_count <= 0;
      refused    <= 0;
      pending    <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        if (req.func == bba_pkg::FUNC_ALLOC) outcome_q.push_back(carve_block(req.req_units));
        else outcome_q.push_back(release_block(req.free_addr));
      end
      if (rsp_valid && !rsp_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected transaction, got status %0d addr %0d units %0d", $time,
                   rsp.status, rsp.block_addr, rsp.block_units);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q.pop_front();
          if (want.status != rsp.status || want.block_addr != rsp.block_addr ||
              want.block_units != rsp.block_units) begin
            $display("%0t: mismatch, expected status %0d addr %0d units %0d, got %0d %0d %0d",
                     $time, want.status, want.block_addr, want.block_units,
                     rsp.status, rsp.block_addr, rsp.block_units);
            fail_count <= fail_count + 1;
          end
          if (want.status != bba_pkg::ST_OK) refused <= refused + 1;
        end
      end
      pending <= outcome_q.size();
    end
  end

  // Tally outcomes by operation for the end-of-run summary.
  bba_pkg::func_t op_q [$];
  always @(posedge clk) begin
    bba_pkg::func_t op;
    if (rst) begin
      op_q.delete();
      alloc_ok <= 0;
      free_ok  <= 0;
    end else begin
      if (req_valid && !req_stall) op_q.push_back(bba_pkg::func_t'(req.func));
      if (rsp_valid && !rsp_stall && op_q.size() > 0) begin
        op = op_q.pop_front();
        if (rsp.status == bba_pkg::ST_OK && op == bba_pkg::FUNC_ALLOC) alloc_ok <= alloc_ok + 1;
        if (rsp.status == bba_pkg::ST_OK && op == bba_pkg::FUNC_FREE) free_ok <= free_ok + 1;
      end
    end
  end
endmodule

// ===== bench/buddy_block_allocator_tb.sv =====
module buddy_block_allocator_tb;

  // The allocator can scan the whole tree for one request, so the cycle limit is
  // sized from that worst case with margin.
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int RANDOM_ITEMS = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  bba_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  bba_pkg::rsp_t rsp;

  int fail_count;
  int pending;
  int alloc_ok;
  int free_ok;
  int refused;
  int cycles = 0;
  int sent = 0;

  // Start addresses of blocks the allocator has handed out and that are not
  // yet scheduled for release; random frees draw mostly from this list.
  int unsigned    live_addr [$];
  bba_pkg::func_t op_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buddy_block_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  bba_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .alloc_ok   (alloc_ok),
    .free_ok    (free_ok),
    .refused    (refused)
  );

  // Learn which blocks were granted so that frees can target real blocks.
  always @(posedge clk) begin
    bba_pkg::func_t op;
    if (!rst) begin
      if (req_valid && !req_stall) op_q.push_back(bba_pkg::func_t'(req.func));
      if (rsp_valid && !rsp_stall && op_q.size() > 0) begin
        op = op_q.pop_front();
        if (op == bba_pkg::FUNC_ALLOC && rsp.status == bba_pkg::ST_OK) begin
          live_addr.push_back(rsp.block_addr);
        end
      end
    end
  end

  // Present one transaction after a random gap and hold it until it is taken.
  task automatic offer(bba_pkg::func_t f, int unsigned units, int unsigned addr);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid     <= 1'b1;
    req.func      <= f;
    req.req_units <= units[10:0];
    req.free_addr <= addr[9:0];
    do @(posedge clk); while (req_stall);
    sent++;
  endtask

  task automatic random_alloc();
    int unsigned pick;
    int unsigned units;
    pick = $urandom_range(0, 99);
    if (pick < 60) units = $urandom_range(0, 16);
    else if (pick < 90) units = $urandom_range(17, 256);
    else if (pick < 98) units = $urandom_range(257, 1024);
    else units = $urandom_range(1025, 2047);
    offer(bba_pkg::FUNC_ALLOC, units, $urandom_range(0, 1023));
  endtask

  task automatic random_free();
    int idx;
    int unsigned addr;
    if (live_addr.size() > 0 && $urandom_range(0, 9) < 8) begin
      idx  = $urandom_range(0, live_addr.size() - 1);
      addr = live_addr[idx];
      live_addr.delete(idx);
    end else begin
      // Stray address: usually inside a block, in free space or already freed.
      addr = $urandom_range(0, 1023);
    end
    offer(bba_pkg::FUNC_FREE, $urandom_range(0, 2047), addr);
  endtask

  // Receiver: random stalls per transaction, runs of no stall, and one long
  // hold so the block fills its output register and stalls its input.
  initial begin
    int n;
    int taken;
    taken = 0;
    forever begin
      if (taken == 200) n = 400;
      else if ((taken / 40) % 3 == 1) n = 0;
      else n = $urandom_range(0, 14);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: size extremes, merges, and each refusal.
    offer(bba_pkg::FUNC_ALLOC, 0, 0);       // zero means one unit
    offer(bba_pkg::FUNC_ALLOC, 1, 1023);
    offer(bba_pkg::FUNC_ALLOC, 1024, 0);    // pool is split, so no space
    offer(bba_pkg::FUNC_ALLOC, 1025, 0);    // too large
    offer(bba_pkg::FUNC_ALLOC, 2047, 0);    // too large, all bits set
    offer(bba_pkg::FUNC_FREE, 2047, 0);
    offer(bba_pkg::FUNC_FREE, 0, 1);        // merges back to the whole pool
    offer(bba_pkg::FUNC_FREE, 0, 5);        // free space
    offer(bba_pkg::FUNC_ALLOC, 1024, 0);
    offer(bba_pkg::FUNC_FREE, 0, 0);
    offer(bba_pkg::FUNC_ALLOC, 3, 0);
    offer(bba_pkg::FUNC_ALLOC, 512, 0);
    offer(bba_pkg::FUNC_FREE, 0, 2);        // inside an allocated block
    offer(bba_pkg::FUNC_FREE, 0, 1023);
    offer(bba_pkg::FUNC_ALLOC, 700, 0);     // no space
    offer(bba_pkg::FUNC_ALLOC, 4, 0);       // exact fit beside the first block
    offer(bba_pkg::FUNC_FREE, 0, 512);
    offer(bba_pkg::FUNC_FREE, 0, 512);      // double free
    offer(bba_pkg::FUNC_FREE, 0, 0);
    offer(bba_pkg::FUNC_FREE, 0, 4);
    live_addr.delete();

    // Random part: frees balance allocations so the tree keeps churning.
    repeat (RANDOM_ITEMS) begin
      if (live_addr.size() > 24 || $urandom_range(0, 9) < 4) random_free();
      else random_alloc();
    end
    req_valid <= 1'b0;

    // Let the checker count the last accepted transaction before waiting on it.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d transactions: %0d granted, %0d released, %0d refused.",
             sent, alloc_ok, free_ok, refused);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/bba_pkg.sv
design/bba_mem.sv
design/buddy_block_allocator.sv
bench/bba_checker.sv
bench/buddy_block_allocator_tb.sv
